// ===== rtl/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and codes for the linear probing key table.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int KEY_W = 16;
	localparam int OP_W = 2;
	localparam int STATUS_W = 2;
	localparam int SLOT_W = 4;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd2;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_MOD   = 4'b0100,
		S_PROBE = 4'b1000
	} state_t;

endpackage

// ===== rtl/linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing key table with linear probing: insert, search, delete.
//
//   channel  | ports                   | handshake
//   ---------+-------------------------+--------------------------------
//   request  | opcode, key             | taken when start && !busy
//   result   | status, slot            | one-cycle strobe on done
//
// The home slot is the key modulo NUM_SLOTS by reciprocal multiplication in
// steps: quotient estimate, remainder, one correcting subtract. The
// probe then reads one slot a cycle from the slot RAM, probing 1 to
// NUM_SLOTS slots; busy drops with the result beat, so no new request is
// taken before then.
// An unused opcode answers without probing and busy stays low.
// After reset a clearing pass writes every slot empty, busy high.
// The receiver cannot stall: each result beat shows for exactly one cycle.
// ----------------------------------------------------------------------------
module linear_probe_hash_table
	import lpht_pkg::*;
#(
	parameter int NUM_SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [OP_W-1:0]     opcode,
	input  logic [KEY_W-1:0]    key,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [SLOT_W-1:0]   slot
);

	localparam int SW = $clog2(NUM_SLOTS);
	localparam int NW = $clog2(NUM_SLOTS + 1);
	localparam int RW = KEY_W + 1;
	localparam int PW = KEY_W + 32;
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / NUM_SLOTS);

	state_t               state_q;
	logic [OP_W-1:0]      op_q;
	logic [KEY_W-1:0]     key_q;
	logic [1:0]           step_q;
	logic [KEY_W-1:0]     quot_q;
	logic [SW:0]          diff_q;
	logic [SW-1:0]        s_q;
	logic [NW-1:0]        n_q;
	logic [SW-1:0]        clr_q;
	logic                 valid_s1;
	logic [SW-1:0]        addr_s1;
	logic                 done_q;
	logic [STATUS_W-1:0]  status_q;
	logic [SLOT_W-1:0]    slot_q;

	logic [PW-1:0]        prod;
	logic [KEY_W-1:0]     qn;
	logic [SW:0]          diff;
	logic [SW-1:0]        home;
	logic                 op_ok;
	logic [SW-1:0]        s_next;
	logic                 issue;
	logic                 rd_used;
	logic [KEY_W-1:0]     rd_key;
	logic [RW-1:0]        rdata;
	logic                 hit;
	logic                 miss_end;
	logic                 we;
	logic [SW-1:0]        waddr;
	logic [RW-1:0]        wdata;

	// modulo by reciprocal, estimate is low by at most one
	assign prod = PW'(key_q) * PW'(RECIP);
	assign qn = KEY_W'(32'(quot_q) * 32'(NUM_SLOTS));
	assign diff = (SW+1)'(key_q - qn);
	assign home = (diff_q >= (SW+1)'(NUM_SLOTS)) ?
		SW'(diff_q - (SW+1)'(NUM_SLOTS)) : SW'(diff_q);

	assign op_ok = (opcode == OP_INSERT) || (opcode == OP_SEARCH) ||
		(opcode == OP_DELETE);

	assign s_next = (s_q == SW'(NUM_SLOTS - 1)) ? '0 : s_q + SW'(1);
	assign issue = (state_q == S_PROBE) && (n_q != NW'(NUM_SLOTS));

	assign rd_used = rdata[RW-1];
	assign rd_key = rdata[KEY_W-1:0];

	always_comb begin
		if (op_q == OP_INSERT) begin
			hit = valid_s1 && !rd_used;
		end else begin
			hit = valid_s1 && rd_used && (rd_key == key_q);
		end
	end

	assign miss_end = (state_q == S_PROBE) && valid_s1 && !hit && (n_q == NW'(NUM_SLOTS));

	always_comb begin
		we = 1'b0;
		waddr = addr_s1;
		wdata = {1'b1, key_q};
		if (state_q == S_CLEAR) begin
			we = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (state_q == S_PROBE && hit) begin
			we = (op_q == OP_INSERT) || (op_q == OP_DELETE);
			wdata = {(op_q == OP_INSERT), key_q};
		end
	end

	lpht_ram #(
		.WIDTH(RW),
		.DEPTH(NUM_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (issue),
		.raddr (s_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			op_q <= OP_INSERT;
			key_q <= '0;
			step_q <= '0;
			quot_q <= '0;
			diff_q <= '0;
			s_q <= '0;
			n_q <= '0;
			valid_s1 <= 1'b0;
			addr_s1 <= '0;
			done_q <= 1'b0;
			status_q <= STAT_OK;
			slot_q <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					done_q <= 1'b0;
					clr_q <= clr_q + SW'(1);
					if (clr_q == SW'(NUM_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					done_q <= start && !op_ok;
					if (start) begin
						op_q <= opcode;
						key_q <= key;
						step_q <= '0;
						if (op_ok) begin
							state_q <= S_MOD;
						end else begin
							status_q <= STAT_MISSING;
							slot_q <= '0;
						end
					end
				end
				S_MOD: begin
					done_q <= 1'b0;
					step_q <= step_q + 2'd1;
					if (step_q == 2'd0) begin
						quot_q <= prod[PW-1:PW-KEY_W];
					end
					if (step_q == 2'd1) begin
						diff_q <= diff;
					end
					if (step_q == 2'd2) begin
						s_q <= home;
						n_q <= '0;
						valid_s1 <= 1'b0;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					done_q <= hit || miss_end;
					valid_s1 <= issue && !hit && !miss_end;
					if (issue) begin
						addr_s1 <= s_q;
						s_q <= s_next;
						n_q <= n_q + NW'(1);
					end
					if (hit) begin
						status_q <= STAT_OK;
						slot_q <= SLOT_W'(addr_s1);
						state_q <= S_IDLE;
					end else if (miss_end) begin
						status_q <= (op_q == OP_INSERT) ? STAT_FULL : STAT_MISSING;
						slot_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					done_q <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign slot = slot_q;

	a_done_follows_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result beat without a request in progress");

	a_slot_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STAT_OK) |-> (slot == '0))
		else $error("slot not zero on a failed request");

	a_full_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_FULL) |-> (op_q == OP_INSERT))
		else $error("table full reported for a non-insert request");

	a_no_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_MOD) |-> !we)
		else $error("slot RAM written outside clearing or probing");

endmodule

// ===== rtl/lpht_ram.sv =====
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== tb/linear_probe_hash_table_tb.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_tb
// Self-checking bench for the linear probing key table. A short table of
// directed requests (empty table, wraparound, duplicates, full table, unused
// opcode) runs first, then random insert/search/delete traffic over a small
// pool of clustered keys. Every result beat is checked against a local model
// of the slot array or a given answer; the sender idles in random bursts.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_tb
	import lpht_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 16;
	localparam int RANDOM_ITEMS = 800;
	localparam int POOL_SIZE = 24;
	localparam int SETTLE_CYCLES = 48;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
	} answer_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] k;
		bit               typed;
		answer_t          given;
	} plan_row_t;

	localparam int PLAN_ROWS = 27;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [OP_W-1:0]     opcode = '0;
	logic [KEY_W-1:0]    key = '0;
	logic                busy;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;

	logic [KEY_W-1:0] table_key [SLOTS];
	bit               table_used [SLOTS];
	answer_t          lookup_answers [$];
	int               mismatches = 0;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	plan_row_t        plan [PLAN_ROWS];

	linear_probe_hash_table #(
		.NUM_SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.key(key),
		.done(done),
		.status(status),
		.slot(slot)
	);

	always #6 clk = ~clk;

	function automatic answer_t probe_table(input logic [OP_W-1:0] op,
			input logic [KEY_W-1:0] k);
		answer_t res;
		int s;
		int hit;
		res.status = STAT_MISSING;
		res.slot = '0;
		hit = -1;
		s = int'(k) % SLOTS;
		if (op == OP_INSERT) begin
			res.status = STAT_FULL;
			for (int n = 0; n < SLOTS; n++) begin
				if (!table_used[s]) begin
					table_used[s] = 1'b1;
					table_key[s] = k;
					res.status = STAT_OK;
					res.slot = SLOT_W'(s);
					break;
				end
				s = (s + 1 >= SLOTS) ? 0 : s + 1;
			end
		end else if (op == OP_SEARCH || op == OP_DELETE) begin
			for (int n = 0; n < SLOTS; n++) begin
				if (table_used[s] && table_key[s] == k) begin
					hit = s;
					break;
				end
				s = (s + 1 >= SLOTS) ? 0 : s + 1;
			end
			if (hit >= 0) begin
				if (op == OP_DELETE)
					table_used[hit] = 1'b0;
				res.status = STAT_OK;
				res.slot = SLOT_W'(hit);
			end
		end
		return res;
	endfunction

	// one request beat; optional idle burst or full drain afterwards
	task automatic issue(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
			input bit typed, input answer_t given, input bit idle_ok, input bit drain);
		answer_t calc;
		start <= 1'b1;
		opcode <= op;
		key <= k;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		calc = probe_table(op, k);
		lookup_answers.push_back(typed ? given : calc);
		if (drain || (idle_ok && $urandom_range(0, 3) == 0)) begin
			start <= 1'b0;
			opcode <= OP_W'($urandom);
			key <= KEY_W'($urandom);
			if (drain) begin
				while (lookup_answers.size() != 0)
					@(posedge clk);
			end
			if (idle_ok)
				repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin : check_beat
		answer_t want;
		if (arst_n && done) begin
			if (lookup_answers.size() == 0) begin
				$error("result beat with nothing expected: status %0d slot %0d",
					status, slot);
				mismatches++;
			end else begin
				want = lookup_answers.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatches++;
				end
				if (slot !== want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, slot);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#8_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] k;
		int               r;
		int               fill;
		bit               idle_ok;
		answer_t          none;

		none = '{status: STAT_OK, slot: '0};
		for (int i = 0; i < SLOTS; i++) begin
			table_used[i] = 1'b0;
			table_key[i] = '0;
		end

		plan = '{
			'{OP_SEARCH, 16'h0000, 1'b1, '{STAT_MISSING, 4'd0}},
			'{OP_DELETE, 16'hFFFF, 1'b1, '{STAT_MISSING, 4'd0}},
			'{OP_UNUSED, 16'hFFFF, 1'b1, '{STAT_MISSING, 4'd0}},
			'{OP_INSERT, 16'h0000, 1'b1, '{STAT_OK, 4'd0}},
			'{OP_INSERT, 16'hFFFF, 1'b1, '{STAT_OK, 4'd15}},
			'{OP_INSERT, 16'h000F, 1'b0, '{STAT_OK, 4'd0}},
			'{OP_INSERT, 16'h0000, 1'b0, '{STAT_OK, 4'd0}},
			'{OP_SEARCH, 16'h0000, 1'b1, '{STAT_OK, 4'd0}},
			'{OP_DELETE, 16'h0000, 1'b1, '{STAT_OK, 4'd0}},
			'{OP_SEARCH, 16'h0000, 1'b0, '{STAT_OK, 4'd0}},
			'{OP_SEARCH, 16'h000F, 1'b0, '{STAT_OK, 4'd0}},
			'{OP_UNUSED, 16'h000F, 1'b1, '{STAT_MISSING, 4'd0}},
			'{OP_INSERT, 16'h7FF1, 1'b0, '{STAT_OK, 4'd0}},
			'{OP_INSERT, 16'h0010, 1'b0, '{STAT_OK, 4'd0}},
			'{OP_INSERT, 16'hA5A5, 1'b0, '{STAT_OK, 4'd0}},
			'{OP_INSERT, 16'h5A5A, 1'b0, '{STAT_OK, 4'd0}},
			'{OP_INSERT, 16'h0003, 1'b0, '{STAT_OK, 4'd0}},
			'{OP_INSERT, 16'h8000, 1'b0, '{STAT_OK, 4'd0}},
			'{OP_INSERT, 16'h00FF, 1'b0, '{STAT_OK, 4'd0}},
			'{OP_INSERT, 16'h1234, 1'b0, '{STAT_OK, 4'd0}},
			'{OP_INSERT, 16'hFFF0, 1'b0, '{STAT_OK, 4'd0}},
			'{OP_INSERT, 16'h0002, 1'b0, '{STAT_OK, 4'd0}},
			'{OP_INSERT, 16'hC3C3, 1'b0, '{STAT_OK, 4'd0}},
			'{OP_INSERT, 16'h3C3C, 1'b0, '{STAT_OK, 4'd0}},
			'{OP_INSERT, 16'h0101, 1'b0, '{STAT_OK, 4'd0}},
			'{OP_INSERT, 16'h4321, 1'b1, '{STAT_FULL, 4'd0}},
			'{OP_SEARCH, 16'h4321, 1'b1, '{STAT_MISSING, 4'd0}}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < PLAN_ROWS; i++)
			issue(plan[i].op, plan[i].k, plan[i].typed, plan[i].given, 1'b1,
				i == PLAN_ROWS - 1);

		// clustered pool: shared low bits force long probe chains
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = (i % 2 == 0) ? {12'($urandom), 4'($urandom_range(0, 3))}
				: KEY_W'($urandom);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			fill = 0;
			for (int s = 0; s < SLOTS; s++)
				fill += table_used[s];
			r = $urandom_range(0, 99);
			if (fill > 12)
				op = (r < 25) ? OP_INSERT : (r < 55) ? OP_SEARCH
					: (r < 95) ? OP_DELETE : OP_UNUSED;
			else
				op = (r < 45) ? OP_INSERT : (r < 72) ? OP_SEARCH
					: (r < 95) ? OP_DELETE : OP_UNUSED;
			if ($urandom_range(0, 99) < 85)
				k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				k = KEY_W'($urandom);
			if ($urandom_range(0, 49) == 0)
				key_pool[$urandom_range(0, POOL_SIZE - 1)] = KEY_W'($urandom);
			idle_ok = (i < RANDOM_ITEMS - 100) && ((i / 50) % 3 != 2);
			issue(op, k, 1'b0, none, idle_ok,
				(i == RANDOM_ITEMS / 2) || (i == RANDOM_ITEMS - 1));
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && lookup_answers.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/lpht_pkg.sv
rtl/lpht_ram.sv
rtl/linear_probe_hash_table.sv
tb/linear_probe_hash_table_tb.sv
